// ===== hw/rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Candle flicker dimmer package
// Shared types, constants and register indexes of the flicker dimmer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int LEVEL_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUOT_W     = 17;
  localparam int REM_W      = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 17'd20480;
  localparam logic [15:0]        LEVEL_SPAN = 16'd45056;

  localparam logic [15:0] CYCLE_PERIOD_RESET = 16'd72;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_RED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME    = 3'd4;

  localparam logic [4:0] DIV_LAST = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_QUOT,
    S_SCALE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic new_cycle;
    logic mul_ramp;
    logic div_step;
    logic level_from_target;
    logic level_from_q;
    logic scale_en;
    logic out_load;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic ramp_done;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/cfd_in_if.sv =====
// ----------------------------------------------------------------------------
// Tick channel
// Carries the millisecond time and the two random draws of one tick.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        coin;
  logic [4:0]  level_pick;

  modport source (output valid, output now_ms, output coin, output level_pick, input ready);
  modport sink   (input valid, input now_ms, input coin, input level_pick, output ready);
endinterface

// ===== hw/rtl/cfd_out_if.sv =====
// ----------------------------------------------------------------------------
// Colour channel
// Carries one dimmed colour, or a write-free beat on a cycle restart.
// ----------------------------------------------------------------------------
interface cfd_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, output write_enable, output out_red, output out_green,
                  output out_blue, input ready);
  modport sink   (input valid, input write_enable, input out_red, input out_green,
                  input out_blue, output ready);
endinterface

// ===== hw/rtl/candle_flicker_dimmer.sv =====
// ----------------------------------------------------------------------------
// Candle flicker dimmer
// Picks random flicker targets per cycle, ramps the level towards them and
// scales the flame base colour by that level.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  tick      in         now_ms, coin, level_pick
//  color     out        write_enable, out_red, out_green, out_blue
//  cfg       in         cfg_write, cfg_index, cfg_data (no handshake)
//
// A tick is taken in the idle state; its beat enters the output register on
// a cycle restart, via the scale state when the ramp is finished or the ramp
// time is zero, and via the multiply, 17-step divider, quotient and scale
// states while ramping. The next tick is taken once that beat is in the output
// register, which may still wait on color.ready. Synchronous reset clears
// the configuration to its defaults and the levels and start time to zero.
module candle_flicker_dimmer #(
  parameter int LEVEL_STEPS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data,
  cfd_in_if.sink                         tick,
  cfd_out_if.source                      color
);
  import cfd_pkg::*;

  cmd_t    cmd;
  status_t status;

  cfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .status     (status),
    .cmd        (cmd)
  );

  cfd_datapath #(
    .LEVEL_STEPS (LEVEL_STEPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .now_ms       (tick.now_ms),
    .coin         (tick.coin),
    .level_pick   (tick.level_pick),
    .out_ready    (color.ready),
    .out_valid    (color.valid),
    .write_enable (color.write_enable),
    .out_red      (color.out_red),
    .out_green    (color.out_green),
    .out_blue     (color.out_blue),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== hw/rtl/cfd_datapath.sv =====
// ----------------------------------------------------------------------------
// Flicker dimmer datapath
// Configuration, level state, ramp multiplier, radix-2 divider, colour
// scaling and the output register.
// ----------------------------------------------------------------------------
module cfd_datapath #(
  parameter int LEVEL_STEPS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [31:0]                     now_ms,
  input  logic                            coin,
  input  logic [4:0]                      level_pick,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            write_enable,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  input  cfd_pkg::cmd_t                   cmd,
  output cfd_pkg::status_t                status
);
  import cfd_pkg::*;

  localparam logic [8:0]  STEP_MAX     = 9'(LEVEL_STEPS - 1);

  logic [7:0]         base_red;
  logic [7:0]         base_green;
  logic [7:0]         base_blue;
  logic [15:0]        cycle_period;
  logic [15:0]        ramp_time;

  logic [31:0]        now_r;
  logic               coin_r;
  logic [4:0]         pick_r;
  logic [4:0]         pick_sat;
  logic [LEVEL_W-1:0] step_level [32];

  logic [31:0]        cycle_start;
  logic [LEVEL_W-1:0] previous_level;
  logic [LEVEL_W-1:0] target_level;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] delta;
  logic               down;
  logic [15:0]        elapsed_r;
  logic [31:0]        elapsed;

  logic [REM_W-1:0]   rem;
  logic [QUOT_W-1:0]  quot;
  logic [15:0]        divisor;
  logic [4:0]         div_cnt;
  logic [32:0]        product;
  logic [16:0]        trial;
  logic               trial_ge;

  logic [24:0]        level_x255;
  logic [7:0]         scale;
  logic [8:0]         scale_inc;
  logic [16:0]        prod_red;
  logic [16:0]        prod_green;
  logic [16:0]        prod_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_red     <= '0;
      base_green   <= '0;
      base_blue    <= '0;
      cycle_period <= CYCLE_PERIOD_RESET;
      ramp_time    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_RED:     base_red     <= cfg_data[7:0];
        REG_BASE_GREEN:   base_green   <= cfg_data[7:0];
        REG_BASE_BLUE:    base_blue    <= cfg_data[7:0];
        REG_CYCLE_PERIOD: cycle_period <= cfg_data;
        REG_RAMP_TIME:    ramp_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pick_sat = ({4'b0, level_pick} > STEP_MAX) ? STEP_MAX[4:0] : level_pick;

  // Dimmed target levels are fixed by the step count, so they form a table.
  for (genvar k = 0; k < 32; k++) begin : g_step_level
    assign step_level[k] = LEVEL_W'(int'(LEVEL_LOW) + (k * int'(LEVEL_SPAN)) / LEVEL_STEPS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r  <= now_ms;
      coin_r <= coin;
      pick_r <= pick_sat;
    end
  end

  assign elapsed = now_r - cycle_start;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      elapsed_r <= elapsed[15:0];
      down      <= target_level < previous_level;
      delta     <= (target_level < previous_level) ? previous_level - target_level
                                                   : target_level - previous_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_start    <= '0;
      previous_level <= '0;
      target_level   <= '0;
    end else if (cmd.new_cycle) begin
      cycle_start    <= now_r;
      previous_level <= target_level;
      target_level   <= coin_r ? step_level[pick_r] : LEVEL_ONE;
    end
  end

  // The quotient never needs more than seventeen bits, so the top sixteen
  // dividend bits are already the partial remainder before the first step.
  assign product = 33'(delta * elapsed_r);

  assign trial    = {rem, quot[QUOT_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.mul_ramp) begin
      rem     <= product[32:17];
      quot    <= product[16:0];
      divisor <= ramp_time;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      quot    <= {quot[QUOT_W-2:0], trial_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.level_from_target) begin
      level <= target_level;
    end else if (cmd.level_from_q) begin
      level <= down ? previous_level - quot : previous_level + quot;
    end
  end

  assign level_x255 = {level, 8'b0} - {8'b0, level};

  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      scale <= level_x255[23:16];
    end
  end

  assign scale_inc  = {1'b0, scale} + 9'd1;
  assign prod_red   = base_red * scale_inc;
  assign prod_green = base_green * scale_inc;
  assign prod_blue  = base_blue * scale_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      write_enable <= !cmd.out_zero;
      out_red      <= cmd.out_zero ? 8'd0 : prod_red[15:8];
      out_green    <= cmd.out_zero ? 8'd0 : prod_green[15:8];
      out_blue     <= cmd.out_zero ? 8'd0 : prod_blue[15:8];
    end
  end

  always_comb begin
    status.restart   = elapsed > {16'b0, cycle_period};
    status.ramp_done = (ramp_time == 16'd0) || (elapsed >= {16'b0, ramp_time});
    status.div_last  = div_cnt == DIV_LAST;
    status.out_free  = !out_valid || out_ready;
  end

  assert property (@(posedge clk) disable iff (rst) target_level <= LEVEL_ONE)
    else $error("Target level is above full brightness.");
  assert property (@(posedge clk) disable iff (rst)
                   cmd.div_step |-> div_cnt <= DIV_LAST)
    else $error("Divider stepped past its last quotient bit.");
  assert property (@(posedge clk) disable iff (rst)
                   $past(cmd.level_from_q) |-> level <= LEVEL_ONE)
    else $error("Ramped level is above full brightness.");

endmodule

// ===== hw/rtl/cfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Flicker dimmer controller
// Sequences evaluation, multiply, division, scaling and output of one tick.
// ----------------------------------------------------------------------------
module cfd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_valid,
  output logic             tick_ready,
  input  cfd_pkg::status_t status,
  output cfd_pkg::cmd_t    cmd
);
  import cfd_pkg::*;

  state_t state;
  state_t state_next;
  logic   restart_mode;
  logic   restart_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      restart_mode <= 1'b0;
    end else begin
      state        <= state_next;
      restart_mode <= restart_mode_next;
    end
  end

  always_comb begin
    state_next        = state;
    restart_mode_next = restart_mode;
    cmd               = '0;
    tick_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval          = 1'b1;
        restart_mode_next = status.restart;
        if (status.restart) begin
          cmd.new_cycle = 1'b1;
          state_next    = S_EMIT;
        end else if (status.ramp_done) begin
          cmd.level_from_target = 1'b1;
          state_next            = S_SCALE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_ramp = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd.level_from_q = 1'b1;
        state_next       = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.out_zero = restart_mode;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
                   state == S_EMIT && !status.out_free |=> state == S_EMIT)
    else $error("Result left before the output register was free.");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> status.out_free)
    else $error("Output register overwritten while a beat is pending.");
  assert property (@(posedge clk) disable iff (rst)
                   state == S_DIV && status.div_last |=> state == S_QUOT)
    else $error("Divider finish did not hand over to the quotient step.");

endmodule

// ===== test/cfd_color_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flicker dimmer colour checker
// Follows the register port and both channels of the flicker dimmer. It keeps
// its own copy of the levels, the cycle start and the registers, works out
// the colour beat each accepted tick should give and compares every emitted
// beat field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module cfd_color_checker #(
  parameter int LEVEL_STEPS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data,
  cfd_in_if                              tick,
  cfd_out_if                             color,
  output int                             failures,
  output int                             pending,
  output int                             restarts,
  output int                             lit_beats
);
  import cfd_pkg::*;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_beat_t;

  color_beat_t expected_colors[$];

  logic [7:0]         base_red;
  logic [7:0]         base_green;
  logic [7:0]         base_blue;
  logic [15:0]        cycle_period;
  logic [15:0]        ramp_time;
  logic [LEVEL_W-1:0] level_from;
  logic [LEVEL_W-1:0] level_to;
  logic [31:0]        cycle_start;

  function automatic logic [7:0] dim_channel(logic [7:0] base, logic [8:0] scale);
    logic [16:0] product;
    product = base * (scale + 9'd1);
    return product[15:8];
  endfunction

  function automatic color_beat_t flicker_step(logic [31:0] now, logic coin,
                                               logic [4:0] pick);
    logic [31:0]        elapsed;
    int unsigned        step_idx;
    logic [LEVEL_W-1:0] diff;
    logic [63:0]        delta;
    logic [LEVEL_W-1:0] level;
    logic [24:0]        wide;
    logic [8:0]         scale;
    color_beat_t        beat;
    beat = '0;
    elapsed = now - cycle_start;
    if (elapsed > {16'd0, cycle_period}) begin
      cycle_start = now;
      level_from = level_to;
      if (!coin) begin
        level_to = LEVEL_ONE;
      end else begin
        step_idx = (pick >= LEVEL_STEPS) ? LEVEL_STEPS - 1 : pick;
        level_to = LEVEL_LOW + LEVEL_W'((64'(step_idx) * 64'(LEVEL_SPAN)) / 64'(LEVEL_STEPS));
      end
      restarts++;
      return beat;
    end
    if (ramp_time == 16'd0 || elapsed >= {16'd0, ramp_time}) begin
      level = level_to;
    end else if (level_to >= level_from) begin
      diff = level_to - level_from;
      delta = (64'(diff) * 64'(elapsed)) / 64'(ramp_time);
      level = level_from + LEVEL_W'(delta);
    end else begin
      diff = level_from - level_to;
      delta = (64'(diff) * 64'(elapsed)) / 64'(ramp_time);
      level = level_from - LEVEL_W'(delta);
    end
    wide = 25'd255 * level;
    scale = wide[24:16];
    if (scale > 9'd255) begin
      scale = 9'd255;
    end
    beat.write_enable = 1'b1;
    beat.red = dim_channel(base_red, scale);
    beat.green = dim_channel(base_green, scale);
    beat.blue = dim_channel(base_blue, scale);
    lit_beats++;
    return beat;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    color_beat_t want;
    if (rst) begin
      base_red = '0;
      base_green = '0;
      base_blue = '0;
      cycle_period = CYCLE_PERIOD_RESET;
      ramp_time = '0;
      level_from = '0;
      level_to = '0;
      cycle_start = '0;
      expected_colors.delete();
      failures = 0;
      restarts = 0;
      lit_beats = 0;
    end else begin
      if (color.valid && color.ready) begin
        if (expected_colors.size() == 0) begin
          $error("colour beat emitted with no tick waiting for it");
          failures++;
        end else begin
          want = expected_colors.pop_front();
          check_field("write_enable", want.write_enable, color.write_enable);
          check_field("out_red", want.red, color.out_red);
          check_field("out_green", want.green, color.out_green);
          check_field("out_blue", want.blue, color.out_blue);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_BASE_RED: begin
            base_red = cfg_data[7:0];
          end
          REG_BASE_GREEN: begin
            base_green = cfg_data[7:0];
          end
          REG_BASE_BLUE: begin
            base_blue = cfg_data[7:0];
          end
          REG_CYCLE_PERIOD: begin
            cycle_period = cfg_data;
          end
          REG_RAMP_TIME: begin
            ramp_time = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (tick.valid && tick.ready) begin
        expected_colors.push_back(flicker_step(tick.now_ms, tick.coin, tick.level_pick));
      end
    end
    pending = expected_colors.size();
  end

endmodule

// ===== test/tb_candle_flicker_dimmer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flicker dimmer testbench
// Drives directed and random ticks through a series of register settings,
// with random gaps on the tick side and random stalls on the colour side,
// and leaves the checking of every colour beat to the colour checker.
// ----------------------------------------------------------------------------
module tb_candle_flicker_dimmer;
  import cfd_pkg::*;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] period;
    logic [15:0] ramp;
  } settings_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic        idle_on;
  logic        hold_request;
  logic        hold_served;
  logic [31:0] now_track;
  int          ticks_sent;
  int          failures;
  int          pending;
  int          restarts;
  int          lit_beats;

  cfd_in_if  tick_bus ();
  cfd_out_if color_bus ();

  candle_flicker_dimmer #(
    .LEVEL_STEPS(24)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_bus),
    .color     (color_bus)
  );

  cfd_color_checker #(
    .LEVEL_STEPS(24)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_bus),
    .color     (color_bus),
    .failures  (failures),
    .pending   (pending),
    .restarts  (restarts),
    .lit_beats (lit_beats)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $error("run did not complete in time, %0d colour beats outstanding", pending);
    $display("FAIL candle_flicker_dimmer");
    $finish;
  end

  task automatic load_settings(input settings_t s);
    logic [CFG_IDX_W-1:0]  reg_index [5];
    logic [CFG_DATA_W-1:0] reg_value [5];
    reg_index = '{REG_BASE_RED, REG_BASE_GREEN, REG_BASE_BLUE, REG_CYCLE_PERIOD,
                  REG_RAMP_TIME};
    reg_value = '{s.red, s.green, s.blue, s.period, s.ramp};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_data <= reg_value[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_tick(input logic [31:0] now, input logic coin, input logic [4:0] pick);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      tick_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.now_ms <= now;
    tick_bus.coin <= coin;
    tick_bus.level_pick <= pick;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    @(negedge clk);
    now_track = now;
    ticks_sent++;
  endtask

  task automatic drain();
    tick_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // The colour side: random stalls, and one long hold so that the block backs up.
  initial begin
    int gap;
    int hold;
    gap = 0;
    hold = 0;
    hold_served = 1'b0;
    color_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold = 400;
        hold_served = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        color_bus.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        color_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        gap = $urandom_range(1, 13) - 1;
        color_bus.ready <= 1'b0;
      end else begin
        color_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    settings_t   s;
    int unsigned span;
    logic [31:0] next_ms;
    logic [4:0]  pick;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_bus.valid = 1'b0;
    tick_bus.now_ms = '0;
    tick_bus.coin = 1'b0;
    tick_bus.level_pick = '0;
    idle_on = 1'b1;
    hold_request = 1'b0;
    now_track = '0;
    ticks_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero ramp time: restarts, boundary of the period, saturated picks, time wrap.
    load_settings('{16'd255, 16'd255, 16'd255, 16'd10, 16'd0});
    send_tick(32'd0, 1'b1, 5'd5);
    send_tick(32'd5, 1'b0, 5'd0);
    send_tick(32'd11, 1'b0, 5'd0);
    send_tick(32'd11, 1'b1, 5'd31);
    send_tick(32'd21, 1'b1, 5'd0);
    send_tick(32'd22, 1'b1, 5'd0);
    send_tick(32'd30, 1'b0, 5'd7);
    send_tick(32'd33, 1'b1, 5'd23);
    send_tick(32'd33, 1'b0, 5'd0);
    send_tick(32'd44, 1'b1, 5'd31);
    send_tick(32'd50, 1'b1, 5'd0);
    send_tick(32'hFFFF_FFF0, 1'b1, 5'd24);
    send_tick(32'hFFFF_FFFF, 1'b0, 5'd0);
    send_tick(32'h0000_0005, 1'b1, 5'd0);
    drain();

    // Ramping down from full brightness, then back up.
    load_settings('{16'd255, 16'd128, 16'd1, 16'd40, 16'd20});
    send_tick(32'd100, 1'b1, 5'd0);
    send_tick(32'd100, 1'b0, 5'd31);
    send_tick(32'd105, 1'b1, 5'd31);
    send_tick(32'd110, 1'b0, 5'd12);
    send_tick(32'd119, 1'b1, 5'd3);
    send_tick(32'd120, 1'b0, 5'd0);
    send_tick(32'd140, 1'b1, 5'd31);
    send_tick(32'd141, 1'b0, 5'd0);
    send_tick(32'd151, 1'b1, 5'd16);
    send_tick(32'd160, 1'b0, 5'd8);
    send_tick(32'd161, 1'b1, 5'd31);

    for (int phase = 0; phase < 7; phase++) begin
      drain();
      case (phase)
        0: begin
          s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        end
        1: begin
          s = '{16'h00FF, 16'hFFFF, 16'h01FF, 16'hFFFF, 16'hFFFF};
        end
        2: begin
          s = '{16'd255, 16'd200, 16'd100, 16'd72, 16'd64};
        end
        3: begin
          s = '{16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom_range(1, 300)), 16'($urandom_range(0, 350))};
        end
        4: begin
          s = '{16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()), 16'($urandom())};
        end
        5: begin
          s = '{16'd1, 16'd1, 16'd1, 16'd100, 16'hFFFF};
        end
        default: begin
          s = '{16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                16'($urandom_range(0, 255)), 16'($urandom_range(1, 120)),
                16'($urandom_range(0, 150))};
        end
      endcase
      load_settings(s);
      idle_on = (phase != 4 && phase != 6);
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < 280; n++) begin
        span = s.period / 4 + 1;
        case ($urandom_range(0, 19))
          0: begin
            next_ms = $urandom();
          end
          1: begin
            next_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * s.period + 2);
          end
          2, 3: begin
            next_ms = now_track + s.period + 1 + $urandom_range(0, 500);
          end
          default: begin
            next_ms = now_track + $urandom_range(0, span);
          end
        endcase
        if ($urandom_range(0, 4) == 0) begin
          pick = 5'($urandom_range(24, 31));
        end else begin
          pick = 5'($urandom_range(0, 23));
        end
        send_tick(next_ms, 1'($urandom_range(0, 1)), pick);
      end
    end
    drain();
    repeat (30) @(negedge clk);

    $display("Drove %0d ticks through nine register settings, including wraps of the time.",
             ticks_sent);
    $display("Checked %0d cycle restarts and %0d lit colour beats.", restarts, lit_beats);
    if (failures == 0 && pending == 0) begin
      $display("PASS candle_flicker_dimmer");
    end else begin
      $display("FAIL candle_flicker_dimmer");
    end
    $finish;
  end

endmodule
